// ===== hw/rtl/ngh_pkg.sv =====
// Package for the noise gate / high-pass filter core: sample and coefficient widths,
// register indexes, reset values and the structs shared by the top level and datapath.
// No dependencies.
`default_nettype none

package ngh_pkg;

   // Sample and coefficient formats
   localparam int SAMPLE_BITS     = 16;
   localparam int ALPHA_FRAC_BITS = 16;
   localparam int THRESH_BITS     = 16;

   // Derived datapath widths
   localparam int STATE_BITS = SAMPLE_BITS + 2;                    // filter output state
   localparam int ACC_BITS   = SAMPLE_BITS + 3;                    // y_prev + x - x_prev
   localparam int PROD_BITS  = ACC_BITS + ALPHA_FRAC_BITS + 1;     // acc * alpha
   localparam int CMP_BITS   = (SAMPLE_BITS + 1 > THRESH_BITS + 1) ?
                               (SAMPLE_BITS + 1) : (THRESH_BITS + 1);

   // Control/status port
   localparam int CSR_DATA_BITS  = (THRESH_BITS > ALPHA_FRAC_BITS) ?
                                   THRESH_BITS : ALPHA_FRAC_BITS;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GATE_ENABLE    = 2'd0,
      CSR_GATE_THRESHOLD = 2'd1,
      CSR_FILTER_ENABLE  = 2'd2,
      CSR_FILTER_ALPHA   = 2'd3
   } csr_index_type;

   localparam logic [THRESH_BITS-1:0]     GATE_THRESHOLD_RESET = THRESH_BITS'(33);
   localparam logic [ALPHA_FRAC_BITS-1:0] FILTER_ALPHA_RESET   = ALPHA_FRAC_BITS'(65092);

   typedef struct packed {
      logic                       gate_enable;
      logic [THRESH_BITS-1:0]     gate_threshold;
      logic                       filter_enable;
      logic [ALPHA_FRAC_BITS-1:0] filter_alpha;
   } ngh_cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] last_in;
      logic signed [STATE_BITS-1:0]  last_out;
   } ngh_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/noise_gate_highpass_filter_core.sv =====
// Top level of the noise gate / high-pass filter core: handshake pipeline,
// control registers and filter state. Depends on ngh_pkg and ngh_datapath.
`default_nettype none

// Usage
//  - req channel: one signed audio sample per transaction, taken at a rising edge
//    with req_valid high and req_stall low.
//  - rsp channel: one gated, filtered and clipped sample per transaction, taken
//    at a rising edge with rsp_valid high and rsp_stall low. Order is preserved.
//  - csr port: write gate_enable (0), gate_threshold (1), filter_enable (2) or
//    filter_alpha (3) with csr_write_en; write only while no transaction is in
//    flight. Writing either filter register clears the filter history.
//  - Path: a sample accepted on req loads the input register, then moves to the
//    result register, from which it is taken on rsp.
//  - Throughput: one transaction per cycle while rsp_stall is low. The filter
//    recursion is combinational, a single 19x17 multiply, round and saturate.
//  - Stall: a stalled result holds in the result register while the input
//    register still takes one more sample; req_stall rises only when both are
//    full and rsp_stall is high.
//  - Reset (synchronous, active high): empties both stages, loads register
//    defaults (gate off, threshold 33, filter off, alpha 65092) and zeroes
//    the filter history.

module noise_gate_highpass_filter_core import ngh_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,

   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   ngh_cfg_type                   cfg_ff, cfg_in;
   ngh_state_type                 state_ff, state_in, state_next;
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic signed [SAMPLE_BITS-1:0] dp_sample_out;
   logic                          out_adv;
   logic                          s1_fire;
   logic                          req_accept;
   logic                          filter_clear;

   // Handshake: result register advances when empty or drained
   assign out_adv    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_adv;
   assign req_stall  = s1_valid_ff && !out_adv;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !out_adv);

   // Control register writes
   always_comb begin
      cfg_in       = cfg_ff;
      filter_clear = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GATE_ENABLE: begin
               cfg_in.gate_enable = csr_wdata[0];
            end
            CSR_GATE_THRESHOLD: begin
               cfg_in.gate_threshold = csr_wdata[THRESH_BITS-1:0];
            end
            CSR_FILTER_ENABLE: begin
               cfg_in.filter_enable = csr_wdata[0];
               filter_clear         = 1'b1;
            end
            CSR_FILTER_ALPHA: begin
               cfg_in.filter_alpha = csr_wdata[ALPHA_FRAC_BITS-1:0];
               filter_clear        = 1'b1;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Filter history: clear on filter writes, advance only when the filter runs
   always_comb begin
      state_in = state_ff;
      if (filter_clear) begin
         state_in = '0;
      end else if (s1_fire && cfg_ff.filter_enable) begin
         state_in = state_next;
      end
   end

   ngh_datapath u_datapath (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .sample     (s1_sample_ff),
      .sample_out (dp_sample_out),
      .next_state (state_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         cfg_ff.gate_enable    <= 1'b0;
         cfg_ff.gate_threshold <= GATE_THRESHOLD_RESET;
         cfg_ff.filter_enable  <= 1'b0;
         cfg_ff.filter_alpha   <= FILTER_ALPHA_RESET;
         state_ff              <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: load on their stage's transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_sample_in;
      end
      if (s1_fire) begin
         rsp_sample_ff <= dp_sample_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef SYNTH
   localparam logic signed [STATE_BITS-1:0] ST_LIMIT = STATE_BITS'((1 << (SAMPLE_BITS + 1)) - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // Back-pressure only when both stages hold a transaction
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req_stall raised with a free stage");

   // Filter register writes leave a cleared history
   a_filter_clear: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && (csr_index == CSR_FILTER_ENABLE || csr_index == CSR_FILTER_ALPHA))
      |=> (state_ff == '0))
      else $error("filter history not cleared after filter register write");

   // History holds while the filter is off and no register is written
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!cfg_ff.filter_enable && !csr_write_en) |=> $stable(state_ff))
      else $error("filter history changed while filter disabled");

   // Stored output stays within the saturation range
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.last_out <= ST_LIMIT) && (state_ff.last_out >= -ST_LIMIT))
      else $error("filter history outside saturation range");

   // Clip never lets the most negative code through
   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sample_ff != SMP_MOST_NEG))
      else $error("output sample not clipped");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ngh_datapath.sv =====
// Combinational per-sample datapath: noise gate, first-order high-pass filter step,
// rounding, state saturation and output clip. Depends on ngh_pkg.
`default_nettype none

module ngh_datapath import ngh_pkg::*; (
   input  ngh_cfg_type                   cfg,
   input  ngh_state_type                 state,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] sample_out,
   output ngh_state_type                 next_state
);

   localparam int YW = PROD_BITS + 1 - ALPHA_FRAC_BITS;

   localparam logic signed [PROD_BITS:0]  RND_HALF = (PROD_BITS + 1)'(1) << (ALPHA_FRAC_BITS - 1);
   localparam logic signed [YW-1:0]  ST_MAX_W = YW'((1 << (SAMPLE_BITS + 1)) - 1);
   localparam logic signed [YW-1:0]  ST_MIN_W = -ST_MAX_W;
   localparam logic signed [STATE_BITS-1:0] SMP_MAX_W = STATE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [STATE_BITS-1:0] SMP_MIN_W = -SMP_MAX_W;

   logic signed [CMP_BITS-1:0]        x_ext;
   logic [CMP_BITS-1:0]               mag;
   logic                              gate_hit;
   logic signed [SAMPLE_BITS-1:0]     gated;
   logic signed [ACC_BITS-1:0]        acc;
   logic signed [ALPHA_FRAC_BITS:0]   alpha_s;
   logic signed [PROD_BITS-1:0]       prod;
   logic signed [PROD_BITS:0]         rnd;
   logic signed [YW-1:0]              y_full;
   logic signed [STATE_BITS-1:0]      y_sat;
   logic signed [STATE_BITS-1:0]      pre_clip;
   logic signed [STATE_BITS-1:0]      clipped;

   // Gate: magnitude of the most negative sample is one past the positive max
   assign x_ext    = CMP_BITS'(sample);
   assign mag      = x_ext[CMP_BITS-1] ? CMP_BITS'(-x_ext) : CMP_BITS'(x_ext);
   assign gate_hit = cfg.gate_enable && (mag < CMP_BITS'(cfg.gate_threshold));
   assign gated    = gate_hit ? '0 : sample;

   // Filter step: y = round(alpha * (y_prev + x - x_prev)), ties toward +inf
   assign acc     = ACC_BITS'(state.last_out) + ACC_BITS'(gated) - ACC_BITS'(state.last_in);
   assign alpha_s = signed'({1'b0, cfg.filter_alpha});
   assign prod    = acc * alpha_s;
   assign rnd     = (PROD_BITS + 1)'(prod) + RND_HALF;
   assign y_full  = signed'(rnd[PROD_BITS:ALPHA_FRAC_BITS]);

   always_comb begin
      if (y_full > ST_MAX_W) begin
         y_sat = STATE_BITS'(ST_MAX_W);
      end else if (y_full < ST_MIN_W) begin
         y_sat = STATE_BITS'(ST_MIN_W);
      end else begin
         y_sat = STATE_BITS'(y_full);
      end
   end

   // Output clip to the symmetric sample range
   assign pre_clip = cfg.filter_enable ? y_sat : STATE_BITS'(gated);

   always_comb begin
      if (pre_clip > SMP_MAX_W) begin
         clipped = SMP_MAX_W;
      end else if (pre_clip < SMP_MIN_W) begin
         clipped = SMP_MIN_W;
      end else begin
         clipped = pre_clip;
      end
   end

   assign sample_out          = clipped[SAMPLE_BITS-1:0];
   assign next_state.last_in  = gated;
   assign next_state.last_out = y_sat;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for noise_gate_highpass_filter_core: directed and random samples
// under random valid gaps and result stalls, checked against an in-bench gate/filter predictor.
// Depends on ngh_pkg and the core RTL.
`timescale 1ns / 1ps

module tb import ngh_pkg::*;;

   localparam int     DRAIN_CYCLES   = 4;       // two register stages plus margin
   localparam int     QUIET_LIMIT    = 20000;   // cycles with no transaction before giving up
   localparam int     RANDOM_PHASES  = 17;
   localparam int     PHASE_SAMPLES  = 100;
   localparam int     MAX_REPORTS    = 200;
   localparam longint SMP_MAX        = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint HIST_MAX       = (longint'(1) <<< (SAMPLE_BITS + 1)) - 1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = CSR_GATE_ENABLE;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;

   noise_gate_highpass_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Samples waiting to be sent, and gated/filtered samples predicted for the result side.
   logic signed [SAMPLE_BITS-1:0] samples_to_send[$];
   logic signed [SAMPLE_BITS-1:0] predicted_outputs[$];

   // Shadow copy of the control registers and the filter history.
   logic                       gate_on;
   logic [THRESH_BITS-1:0]     gate_level;
   logic                       hpf_on;
   logic [ALPHA_FRAC_BITS-1:0] hpf_coef;
   longint                     hist_in;
   longint                     hist_out;

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   bit steady_phase   = 1'b0;   // set to run a phase with no gaps and no stalls

   initial begin
      forever #4 clock = ~clock;
   end

   // Gate, then filter, then clip: advance the shadow history exactly as the core does.
   function automatic logic signed [SAMPLE_BITS-1:0] gate_and_filter(
         input logic signed [SAMPLE_BITS-1:0] raw);
      longint x;
      longint mag;
      longint acc;
      longint y;
      x = raw;
      if (gate_on) begin
         // Most negative sample has magnitude 2^(SAMPLE_BITS-1) here, no wrap.
         mag = (x < 0) ? -x : x;
         if (mag < longint'(gate_level))
            x = 0;
      end
      if (hpf_on) begin
         acc = hist_out + x - hist_in;
         // Round to nearest, ties toward plus infinity; >>> floors on signed values.
         y = (acc * longint'(hpf_coef) + (longint'(1) <<< (ALPHA_FRAC_BITS - 1)))
             >>> ALPHA_FRAC_BITS;
         if (y > HIST_MAX)
            y = HIST_MAX;
         else if (y < -HIST_MAX)
            y = -HIST_MAX;
         hist_in  = x;
         hist_out = y;
      end else begin
         y = x;
      end
      if (y > SMP_MAX)
         y = SMP_MAX;
      else if (y < -SMP_MAX)
         y = -SMP_MAX;
      return SAMPLE_BITS'(y);
   endfunction

   // Mostly zero, sometimes a short gap, now and then a long pause.
   function automatic int draw_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (steady_phase || r < 65)
         return 0;
      if (r < 92)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(4, 40));
   endfunction

   // One random sample: square wave with noise, near the gate threshold, raw bits or extremes.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int k, input int amp,
                                                                 input int period);
      int     r;
      longint v;
      r = int'($urandom_range(0, 99));
      if (r < 45) begin
         v = (((k / period) % 2) != 0) ? amp : -amp;
         v = v + longint'($urandom_range(0, 64)) - 32;
      end else if (r < 65) begin
         v = longint'(gate_level) + longint'($urandom_range(0, 6)) - 3;
         if ($urandom_range(0, 1) != 0)
            v = -v;
      end else if (r < 90) begin
         return SAMPLE_BITS'($urandom);
      end else begin
         case ($urandom_range(0, 3))
            0:       v = -SMP_MAX - 1;
            1:       v = SMP_MAX;
            2:       v = 0;
            default: v = -1;
         endcase
      end
      if (v > SMP_MAX)
         v = SMP_MAX;
      else if (v < -SMP_MAX - 1)
         v = -SMP_MAX - 1;
      return SAMPLE_BITS'(v);
   endfunction

   function automatic void clear_shadow();
      gate_on    = 1'b0;
      gate_level = GATE_THRESHOLD_RESET;
      hpf_on     = 1'b0;
      hpf_coef   = FILTER_ALPHA_RESET;
      hist_in    = 0;
      hist_out   = 0;
   endfunction

   // Write one register: strobe for one cycle and mirror it in the shadow copy.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         CSR_GATE_ENABLE:    gate_on    = val[0];
         CSR_GATE_THRESHOLD: gate_level = val[THRESH_BITS-1:0];
         CSR_FILTER_ENABLE: begin
            hpf_on   = val[0];
            hist_in  = 0;
            hist_out = 0;
         end
         CSR_FILTER_ALPHA: begin
            hpf_coef = val[ALPHA_FRAC_BITS-1:0];
            hist_in  = 0;
            hist_out = 0;
         end
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send(input longint v);
      samples_to_send = {samples_to_send, SAMPLE_BITS'(v)};
   endtask

   // Wait until every sample went out and every result came back; sample at the falling
   // edge so the queues and valid are settled for this cycle.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (samples_to_send.size() != 0 || req_valid || predicted_outputs.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Driver: record the prediction when a transaction is taken, hold a stalled payload,
   // then load the next sample after a random gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall)
            predicted_outputs = {predicted_outputs, gate_and_filter(req_sample_in)};
         if (req_valid && req_stall) begin
            // hold the stalled transaction as it is
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (samples_to_send.size() != 0) begin
            req_valid     <= 1'b1;
            req_sample_in <= samples_to_send.pop_front();
            gap_left      <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure: runs of stall of random length, none in steady phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!steady_phase && $urandom_range(0, 99) < 20) begin
         rsp_stall  <= 1'b1;
         stall_left <= draw_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare every result transaction with the oldest prediction.
   always @(posedge clock) begin : check_results
      logic signed [SAMPLE_BITS-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_outputs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual sample_out %0d",
                        $time, rsp_sample_out);
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_sample_out !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                           $time, want, rsp_sample_out);
            end
         end
      end
   end

   // Watchdog: drop the run if no transaction and no register write happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int p;
      int k;
      int amp;
      int period;
      int r;
      logic [CSR_DATA_BITS-1:0] v;

      clear_shadow();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: gate and filter off, the most negative sample clips to -32767.
      send(-SMP_MAX - 1);
      send(SMP_MAX);
      send(0);
      send(-1);
      send(1);
      send(16'sh5555);
      send(-16'sd21846);
      wait_drained();

      // Gate on with upper write bits set, default threshold: check both sides of 33.
      write_reg(CSR_GATE_ENABLE, 16'hFFFF);
      send(32);
      send(33);
      send(-32);
      send(-33);
      send(-SMP_MAX - 1);
      send(0);
      wait_drained();

      // Zero threshold gates nothing; 32768 spares only the most negative sample.
      write_reg(CSR_GATE_THRESHOLD, 16'd0);
      send(0);
      send(1);
      send(-1);
      wait_drained();
      write_reg(CSR_GATE_THRESHOLD, 16'd32768);
      send(-SMP_MAX - 1);
      send(SMP_MAX);
      send(-SMP_MAX);
      wait_drained();
      write_reg(CSR_GATE_THRESHOLD, 16'hFFFF);
      send(-SMP_MAX - 1);
      send(SMP_MAX);
      wait_drained();

      // Gate off via an even value with garbage above bit 0; filter at both alpha extremes.
      write_reg(CSR_GATE_ENABLE, 16'h0002);
      write_reg(CSR_FILTER_ENABLE, 16'h0001);
      write_reg(CSR_FILTER_ALPHA, 16'hFFFF);
      send(SMP_MAX);
      send(-SMP_MAX - 1);
      send(SMP_MAX);
      send(-SMP_MAX - 1);
      send(0);
      wait_drained();
      write_reg(CSR_FILTER_ALPHA, 16'd0);
      send(SMP_MAX);
      send(-1);
      wait_drained();

      // Random phases: reprogram a random subset of registers while idle, then stream.
      // Gate-only writes keep the filter history, so later phases also run on from it.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         steady_phase = ((p % 4) == 3);
         if ($urandom_range(0, 9) < 6)
            write_reg(CSR_GATE_ENABLE, CSR_DATA_BITS'($urandom));
         if ($urandom_range(0, 9) < 6) begin
            r = int'($urandom_range(0, 5));
            case (r)
               0:       v = 0;
               1:       v = 16'd32768;
               2:       v = 16'hFFFF;
               3:       v = CSR_DATA_BITS'($urandom_range(1, 64));
               4:       v = CSR_DATA_BITS'($urandom_range(0, 4000));
               default: v = CSR_DATA_BITS'($urandom);
            endcase
            write_reg(CSR_GATE_THRESHOLD, v);
         end
         if ($urandom_range(0, 9) < 6)
            write_reg(CSR_FILTER_ENABLE, CSR_DATA_BITS'($urandom));
         if ($urandom_range(0, 9) < 5) begin
            r = int'($urandom_range(0, 4));
            case (r)
               0:       v = 0;
               1:       v = 16'hFFFF;
               2:       v = FILTER_ALPHA_RESET;
               3:       v = CSR_DATA_BITS'($urandom_range(60000, 65535));
               default: v = CSR_DATA_BITS'($urandom);
            endcase
            write_reg(CSR_FILTER_ALPHA, v);
         end
         amp    = int'($urandom_range(0, 32767));
         period = int'($urandom_range(1, 40));
         for (k = 0; k < PHASE_SAMPLES; k++)
            samples_to_send = {samples_to_send, pick_sample(k, amp, period)};
         wait_drained();
      end

      if (predicted_outputs.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d expected results never arrived", $time, predicted_outputs.size());
      end
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
